@@ hdl/lcfr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lcfr_pkg
// Types and constants shared by the length and checksum frame receiver.
// ----------------------------------------------------------------------------
package lcfr_pkg;

    localparam int unsigned BUF_SIZE_W = 11;
    localparam int unsigned POS_W      = 17;

    localparam logic [POS_W-1:0] HEADER_BYTES = 17'd3;

    localparam logic [7:0] FRAME_ID_RESET = 8'h41;

    localparam logic CFG_BUFFER_SIZE = 1'b0;
    localparam logic CFG_FRAME_ID    = 1'b1;

    localparam logic MODE_BYTE    = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_RECV = 2'd1,
        PH_HELD = 2'd2
    } t_phase;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [9:0]  write_index;
        logic [7:0]  write_byte;
        logic        frame_ok;
        logic        checksum_match;
        logic        length_fits;
        logic [15:0] frame_length;
    } t_out_item;

    typedef struct packed {
        logic [BUF_SIZE_W-1:0] buffer_size;
        logic [7:0]            frame_id;
    } t_cfg;

endpackage
`default_nettype wire

@@ hdl/lcfr_parser.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lcfr_parser
// Frame state and per-byte decode: one item per step, at most one result.
// ----------------------------------------------------------------------------
module lcfr_parser #(
    parameter int unsigned BUFFER_DEPTH = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire lcfr_pkg::t_in_item i_item,
    input  wire lcfr_pkg::t_cfg     i_cfg,
    output logic                    o_res_valid,
    output lcfr_pkg::t_out_item     o_res
);

    localparam logic [lcfr_pkg::POS_W-1:0] DEPTH_W = lcfr_pkg::POS_W'(BUFFER_DEPTH);

    lcfr_pkg::t_phase              r_phase, n_phase;
    logic [lcfr_pkg::POS_W-1:0]    r_pos, n_pos;
    logic [7:0]                    r_len_low, n_len_low;
    logic [15:0]                   r_len, n_len;
    logic [7:0]                    r_sum, n_sum;

    logic [lcfr_pkg::POS_W-1:0]    buf_size_w;
    logic [lcfr_pkg::POS_W-1:0]    cap;
    logic [lcfr_pkg::POS_W-1:0]    last;
    logic [lcfr_pkg::POS_W-1:0]    idx;
    logic [7:0]                    sum_next;
    logic                          in_data;
    logic                          match;
    logic                          fits;

    assign buf_size_w = lcfr_pkg::POS_W'(i_cfg.buffer_size);
    assign cap        = (buf_size_w < DEPTH_W) ? buf_size_w : DEPTH_W;
    assign last       = lcfr_pkg::POS_W'(r_len) + lcfr_pkg::HEADER_BYTES;
    assign idx        = r_pos - lcfr_pkg::HEADER_BYTES;
    assign sum_next   = r_sum + i_item.rx_byte;
    assign in_data    = (r_pos < last);
    assign match      = (i_item.rx_byte == r_sum);
    assign fits       = (lcfr_pkg::POS_W'(r_len) <= cap);

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_len_low = r_len_low;
        n_len     = r_len;
        n_sum     = r_sum;
        if (i_item.mode == lcfr_pkg::MODE_RELEASE) begin
            n_phase = lcfr_pkg::PH_IDLE;
            n_pos   = '0;
        end else begin
            case (r_phase)
                lcfr_pkg::PH_HELD: begin
                end
                lcfr_pkg::PH_RECV: begin
                    if (r_pos == lcfr_pkg::POS_W'(1)) begin
                        n_len_low = i_item.rx_byte;
                        n_pos     = lcfr_pkg::POS_W'(2);
                    end else if (r_pos == lcfr_pkg::POS_W'(2)) begin
                        n_len = {i_item.rx_byte, r_len_low};
                        n_pos = lcfr_pkg::HEADER_BYTES;
                    end else if (in_data) begin
                        n_sum = sum_next;
                        n_pos = r_pos + lcfr_pkg::POS_W'(1);
                    end else begin
                        n_phase = (match && fits) ? lcfr_pkg::PH_HELD : lcfr_pkg::PH_IDLE;
                        n_pos   = '0;
                    end
                end
                default: begin
                    if (i_item.rx_byte == i_cfg.frame_id) begin
                        n_phase   = lcfr_pkg::PH_RECV;
                        n_pos     = lcfr_pkg::POS_W'(1);
                        n_sum     = '0;
                        n_len_low = '0;
                        n_len     = '0;
                    end
                end
            endcase
        end
    end

    // result
    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '0;
        if ((i_item.mode == lcfr_pkg::MODE_BYTE) && (r_phase == lcfr_pkg::PH_RECV)
                && (r_pos >= lcfr_pkg::HEADER_BYTES)) begin
            if (in_data) begin
                if (idx < cap) begin
                    o_res_valid       = 1'b1;
                    o_res.kind        = lcfr_pkg::KIND_WRITE;
                    o_res.write_index = idx[9:0];
                    o_res.write_byte  = i_item.rx_byte;
                end
            end else begin
                o_res_valid          = 1'b1;
                o_res.kind           = lcfr_pkg::KIND_STATUS;
                o_res.frame_ok       = match & fits;
                o_res.checksum_match = match;
                o_res.length_fits    = fits;
                o_res.frame_length   = r_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= lcfr_pkg::PH_IDLE;
            r_pos     <= '0;
            r_len_low <= '0;
            r_len     <= '0;
            r_sum     <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_len_low <= n_len_low;
            r_len     <= n_len;
            r_sum     <= n_sum;
        end
    end

`ifndef SYNTHESIS
    a_status_leaves_recv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res_valid && (o_res.kind == lcfr_pkg::KIND_STATUS)
        |=> (r_phase != lcfr_pkg::PH_RECV) && (r_pos == '0))
        else $error("status transfer did not close the frame");

    a_held_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == lcfr_pkg::PH_HELD) && (i_item.mode == lcfr_pkg::MODE_BYTE)
        |-> !o_res_valid)
        else $error("held receiver produced a result");

    a_write_in_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_res.kind == lcfr_pkg::KIND_WRITE) |-> (idx < cap))
        else $error("buffer write beyond capacity");

    a_held_only_when_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (r_phase != lcfr_pkg::PH_HELD) && (n_phase == lcfr_pkg::PH_HELD)
        |-> o_res_valid && o_res.frame_ok)
        else $error("receiver held without a good frame");
`endif

endmodule
`default_nettype wire

@@ hdl/length_checksum_frame_receiver.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// length_checksum_frame_receiver
// Byte-framed receiver with 16-bit length and 8-bit additive checksum.
// ----------------------------------------------------------------------------
// usage
//   input channel: one item per transfer, either a received link byte or a
//   release that frees a held buffer and re-arms the receiver
//   output channel: at most one result per input item, a buffer write for
//   each data byte within capacity or a status on the checksum byte
//   config port: write enable, register index (0 buffer_size, 1 frame_id)
//   and data; write only while no item is in flight
// pipeline and throughput
//   an accepted item lands in an input register, is decoded from it and
//   its result is registered in the output register when the output can
//   advance; one item per cycle is sustained while the output is taken,
//   set by the single decode stage between the input and output registers
// reset
//   synchronous active-low reset empties both registers, puts the receiver
//   in idle waiting for the frame ID, buffer_size to 0 and frame_id to 'A'
// stall
//   when the output is not taken the decode stage holds; the input register
//   still takes one more item, then ready drops until the output drains
// ----------------------------------------------------------------------------
module length_checksum_frame_receiver #(
    parameter int unsigned BUFFER_DEPTH = 1024
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire lcfr_pkg::t_in_item           i_in_item,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output lcfr_pkg::t_out_item               o_out_item,
    input  wire logic                         i_cfg_we,
    input  wire logic                         i_cfg_index,
    input  wire logic [lcfr_pkg::BUF_SIZE_W-1:0] i_cfg_data
);

    lcfr_pkg::t_cfg      r_cfg;
    logic                r_in_valid;
    lcfr_pkg::t_in_item  r_in;
    logic                r_out_valid;
    lcfr_pkg::t_out_item r_out;

    logic                advance;
    logic                step;
    logic                res_valid;
    lcfr_pkg::t_out_item res;

    assign advance     = !r_out_valid || i_out_ready;
    assign step        = r_in_valid && advance;
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.buffer_size <= '0;
            r_cfg.frame_id    <= lcfr_pkg::FRAME_ID_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lcfr_pkg::CFG_BUFFER_SIZE: r_cfg.buffer_size <= i_cfg_data;
                lcfr_pkg::CFG_FRAME_ID:    r_cfg.frame_id    <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    lcfr_parser #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (r_in),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

endmodule
`default_nettype wire

@@ sim/length_checksum_frame_receiver_tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// length_checksum_frame_receiver_tb
// Self-checking bench for the length and checksum frame receiver. A
// behavioral model of the framing logic predicts every buffer write and
// end-of-frame status as each byte or release is transferred in. Results
// are checked in order against the model. Directed frames cover the reset
// configuration, config extremes, the held state and release, and capacity
// above the buffer depth. Random traffic mixes good and corrupt frames,
// truncated frames and line noise under varying flow control.
// ----------------------------------------------------------------------------
module length_checksum_frame_receiver_tb;

    localparam int unsigned BUFFER_DEPTH  = 1024;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned MAX_REPORTS   = 10;
    localparam int unsigned RANDOM_ITEMS  = 585;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_in_valid  = 1'b0;
    lcfr_pkg::t_in_item              i_in_item   = '0;
    logic                            i_out_ready = 1'b0;
    logic                            i_cfg_we    = 1'b0;
    logic                            i_cfg_index = lcfr_pkg::CFG_BUFFER_SIZE;
    logic [lcfr_pkg::BUF_SIZE_W-1:0] i_cfg_data  = '0;
    logic                            o_in_ready;
    logic                            o_out_valid;
    lcfr_pkg::t_out_item             o_out_item;

    // receiver model state and its copy of the registers
    lcfr_pkg::t_phase                rx_phase   = lcfr_pkg::PH_IDLE;
    logic [lcfr_pkg::POS_W-1:0]      rx_pos     = '0;
    logic [7:0]                      rx_len_low = '0;
    logic [15:0]                     rx_len     = '0;
    logic [7:0]                      rx_sum     = '0;
    logic [lcfr_pkg::BUF_SIZE_W-1:0] cap_reg    = '0;
    logic [7:0]                      id_reg     = lcfr_pkg::FRAME_ID_RESET;

    lcfr_pkg::t_out_item pending_results[$];
    int unsigned fail_count    = 0;
    int unsigned stall_cycles  = 0;
    int unsigned in_gap_pct    = 10;
    int unsigned out_stall_pct = 64;
    int unsigned sent_items    = 0;

    length_checksum_frame_receiver #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic void frame_predict(input lcfr_pkg::t_in_item item);
        lcfr_pkg::t_out_item res;
        int unsigned         usable;
        res = '0;
        usable = (cap_reg < BUFFER_DEPTH) ? cap_reg : BUFFER_DEPTH;
        if (item.mode == lcfr_pkg::MODE_RELEASE) begin
            rx_phase = lcfr_pkg::PH_IDLE;
            rx_pos = '0;
        end else if (rx_phase == lcfr_pkg::PH_HELD) begin
            // bytes ignored until release
        end else if (rx_phase != lcfr_pkg::PH_RECV) begin
            if (item.rx_byte == id_reg) begin
                rx_phase = lcfr_pkg::PH_RECV;
                rx_pos = 17'd1;
                rx_sum = '0;
                rx_len_low = '0;
                rx_len = '0;
            end
        end else if (rx_pos == 17'd1) begin
            rx_len_low = item.rx_byte;
            rx_pos = 17'd2;
        end else if (rx_pos == 17'd2) begin
            rx_len = {item.rx_byte, rx_len_low};
            rx_pos = 17'd3;
        end else if (32'(rx_pos) < 32'(rx_len) + 32'(lcfr_pkg::HEADER_BYTES)) begin
            rx_sum = rx_sum + item.rx_byte;
            if (32'(rx_pos - lcfr_pkg::HEADER_BYTES) < usable) begin
                res.kind = lcfr_pkg::KIND_WRITE;
                res.write_index = 10'(rx_pos - lcfr_pkg::HEADER_BYTES);
                res.write_byte = item.rx_byte;
                pending_results.push_back(res);
            end
            rx_pos = rx_pos + 17'd1;
        end else begin
            res.kind = lcfr_pkg::KIND_STATUS;
            res.checksum_match = (item.rx_byte == rx_sum);
            res.length_fits = (32'(rx_len) <= usable);
            res.frame_ok = res.checksum_match & res.length_fits;
            res.frame_length = rx_len;
            pending_results.push_back(res);
            rx_phase = res.frame_ok ? lcfr_pkg::PH_HELD : lcfr_pkg::PH_IDLE;
            rx_pos = '0;
        end
    endfunction

    function automatic void report_failure(input string what,
                                           input lcfr_pkg::t_out_item want,
                                           input lcfr_pkg::t_out_item got);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%s: expected kind=%0d idx=%0d byte=%h ok=%b match=%b fits=%b len=%0d",
                     what, want.kind, want.write_index, want.write_byte, want.frame_ok,
                     want.checksum_match, want.length_fits, want.frame_length);
            $display("    actual   kind=%0d idx=%0d byte=%h ok=%b match=%b fits=%b len=%0d",
                     got.kind, got.write_index, got.write_byte, got.frame_ok,
                     got.checksum_match, got.length_fits, got.frame_length);
        end
    endfunction

    function automatic void check_result(input lcfr_pkg::t_out_item got);
        lcfr_pkg::t_out_item want;
        if (pending_results.size() == 0) begin
            report_failure("result with nothing pending", '0, got);
        end else begin
            want = pending_results.pop_front();
            if (got.kind !== want.kind || got.write_index !== want.write_index ||
                got.write_byte !== want.write_byte || got.frame_ok !== want.frame_ok ||
                got.checksum_match !== want.checksum_match ||
                got.length_fits !== want.length_fits ||
                got.frame_length !== want.frame_length) begin
                report_failure("result mismatch", want, got);
            end
        end
    endfunction

    // transfer monitor: predicts on input, checks on output
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            frame_predict(i_in_item);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            check_result(o_out_item);
        end
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_item(input logic mode, input logic [7:0] value);
        while ($urandom_range(99) < in_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= '{mode: mode, rx_byte: value};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sent_items++;
    endtask

    // fill below zero means random data bytes
    task automatic send_frame(input logic [15:0] len, input bit bad_sum, input int fill);
        logic [7:0] sum;
        logic [7:0] b;
        sum = '0;
        send_item(lcfr_pkg::MODE_BYTE, id_reg);
        send_item(lcfr_pkg::MODE_BYTE, len[7:0]);
        send_item(lcfr_pkg::MODE_BYTE, len[15:8]);
        repeat (len) begin
            b = (fill < 0) ? 8'($urandom) : 8'(fill);
            sum = sum + b;
            send_item(lcfr_pkg::MODE_BYTE, b);
        end
        if (bad_sum) begin
            sum = sum ^ 8'($urandom_range(1, 255));
        end
        send_item(lcfr_pkg::MODE_BYTE, sum);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [lcfr_pkg::BUF_SIZE_W-1:0] size,
                              input logic [7:0] id);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_index <= lcfr_pkg::CFG_BUFFER_SIZE;
        i_cfg_data <= size;
        @(posedge i_clk);
        i_cfg_index <= lcfr_pkg::CFG_FRAME_ID;
        i_cfg_data <= lcfr_pkg::BUF_SIZE_W'(id);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cap_reg = size;
        id_reg = id;
    endtask

    task automatic test_default_config();
        // idle noise, then frames against a zero-size buffer
        send_item(lcfr_pkg::MODE_BYTE, 8'h00);
        send_item(lcfr_pkg::MODE_BYTE, 8'hFF);
        send_frame(16'd1, 1'b0, 8'hFF);
        send_frame(16'd0, 1'b0, 0);
        send_item(lcfr_pkg::MODE_BYTE, id_reg);
        send_item(lcfr_pkg::MODE_RELEASE, 8'hFF);
    endtask

    task automatic test_config_extremes();
        set_config(11'd2047, 8'h00);
        send_frame(16'd3, 1'b1, 8'h00);
        send_item(lcfr_pkg::MODE_RELEASE, 8'h00);
        set_config(11'd1024, 8'hFF);
        // release in the middle of a header
        send_item(lcfr_pkg::MODE_BYTE, 8'hFF);
        send_item(lcfr_pkg::MODE_BYTE, 8'h05);
        send_item(lcfr_pkg::MODE_RELEASE, 8'h5A);
        send_frame(16'd2, 1'b0, 8'hFF);
        send_item(lcfr_pkg::MODE_RELEASE, 8'hA5);
        set_config(11'd2, 8'h41);
        send_frame(16'd4, 1'b0, -1);
    endtask

    task automatic test_capacity_above_depth();
        // capacity clamps to the buffer depth
        set_config(11'd2047, lcfr_pkg::FRAME_ID_RESET);
        send_frame(16'd1025, 1'b0, -1);
        send_item(lcfr_pkg::MODE_RELEASE, 8'h00);
    endtask

    task automatic random_config();
        int unsigned                     r;
        logic [lcfr_pkg::BUF_SIZE_W-1:0] size;
        r = $urandom_range(99);
        if (r < 60) begin
            size = lcfr_pkg::BUF_SIZE_W'($urandom_range(0, 30));
        end else if (r < 75) begin
            size = lcfr_pkg::BUF_SIZE_W'($urandom_range(0, 2047));
        end else if (r < 85) begin
            size = '0;
        end else begin
            size = '1;
        end
        set_config(size, 8'($urandom));
    endtask

    task automatic test_random_traffic(input int unsigned gap_pct, input int unsigned stall_pct,
                                       input int unsigned quota);
        int unsigned start_items;
        int unsigned seqs;
        int unsigned r;
        int unsigned n;
        logic [7:0]  b;
        in_gap_pct = gap_pct;
        out_stall_pct = stall_pct;
        start_items = sent_items;
        seqs = 0;
        while (sent_items - start_items < quota) begin
            if (seqs % 40 == 0) begin
                random_config();
            end
            seqs++;
            r = $urandom_range(99);
            if (r < 65) begin
                repeat ($urandom_range(0, 2)) begin
                    b = 8'($urandom);
                    if (b == id_reg) begin
                        b = b ^ 8'h01;
                    end
                    send_item(lcfr_pkg::MODE_BYTE, b);
                end
                n = ($urandom_range(99) < 85) ? $urandom_range(0, 20) : $urandom_range(21, 80);
                send_frame(16'(n), $urandom_range(99) < 25, -1);
                repeat ($urandom_range(0, 2)) send_item(lcfr_pkg::MODE_BYTE, 8'($urandom));
            end else if (r < 85) begin
                // truncated frame
                n = $urandom_range(0, 6);
                send_item(lcfr_pkg::MODE_BYTE, id_reg);
                repeat (n) send_item(lcfr_pkg::MODE_BYTE, 8'($urandom));
            end else begin
                repeat ($urandom_range(1, 6)) send_item(1'($urandom), 8'($urandom));
            end
            send_item(lcfr_pkg::MODE_RELEASE, 8'($urandom));
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_config();
        test_config_extremes();
        test_capacity_above_depth();
        test_random_traffic(10, 64, RANDOM_ITEMS / 3);
        test_random_traffic(64, 10, RANDOM_ITEMS / 3);
        test_random_traffic(0, 0, RANDOM_ITEMS / 3);
        wait_idle();
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
